/* src/stream_find_replace_word_core_macros.svh */
// ============================================================================
// Assertion macros for the stream find-and-replace core
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ============================================================================
`ifndef STREAM_FIND_REPLACE_WORD_CORE_MACROS_SVH
`define STREAM_FIND_REPLACE_WORD_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFRW_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sfrw_pkg.sv */
// ============================================================================
// Stream find-and-replace package
// Word types, configuration bundle, queue command format and helpers shared
// by the front end, the command queue, the back end and the top level.
// ============================================================================
package sfrw_pkg;

    // Pattern and replacement registers hold this many packed bytes.
    localparam int PACK_BYTES = 8;

    // Depth of the command queue between front end and back end.
    localparam int Q_DEPTH = 4;

    localparam logic [7:0] UNDERSCORE = 8'h5F;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_PATTERN_BYTES      = 3'd0;
    localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd1;
    localparam logic [2:0] REG_REPLACEMENT_BYTES  = 3'd2;
    localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;
    localparam logic [2:0] REG_WHOLE_WORD_MODE    = 3'd4;

    // Input word.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    // Output word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
        logic        whole_word_mode;
    } t_cfg;

    typedef enum logic {
        CMD_LITERAL,
        CMD_REPLACE
    } t_cmd_kind;

    // One decision of the front end, carried out by the back end.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] lit;
        logic       eot;
        logic       fin;
    } t_cmd;

    // Clamp a length register into [lo, cap].
    function automatic logic [3:0] eff_len(logic [3:0] v, logic [3:0] lo, logic [3:0] cap);
        logic [3:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > cap) begin
            r = cap;
        end
        return r;
    endfunction

    // Letters, digits and underscore make up a word.
    function automatic logic is_word(logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h30) && (c <= 8'h39)) || (c == UNDERSCORE);
    endfunction

endpackage

/* src/sfrw_front.sv */
// ============================================================================
// Stream find-and-replace front end
// Holds the byte window, compares it against the pattern, checks the word
// borders and issues a literal or replacement command for each decision that emits bytes or closes a text.
// ============================================================================
`include "stream_find_replace_word_core_macros.svh"

module sfrw_front #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clear,
    input  sfrw_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sfrw_pkg::t_in i_in_data,
    input  logic          i_q_full,
    output logic          o_push,
    output sfrw_pkg::t_cmd o_cmd
);
    import sfrw_pkg::*;

    localparam int PCAP = (MAX_PATTERN < PACK_BYTES) ? MAX_PATTERN : PACK_BYTES;
    localparam int RCAP = (MAX_REPLACEMENT < PACK_BYTES) ? MAX_REPLACEMENT : PACK_BYTES;
    localparam int WIN  = PCAP + 1;
    localparam int CW   = $clog2(WIN + 1);

    logic [WIN*8-1:0] r_win, n_win;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_skip, n_skip;
    logic [7:0]       r_prev, n_prev;
    logic             r_flush, n_flush;

    logic [CW-1:0]    plen;
    logic [3:0]       rlen;
    logic [CW-1:0]    need;
    logic             acc;
    logic             eot_step;
    logic [WIN*8-1:0] v_flat;
    logic [CW-1:0]    vcnt;
    logic             mismatch;
    logic             matched;
    logic [WIN*8-1:0] nxt_shift;
    logic [7:0]       next_byte;
    logic             border_ok;
    logic             take;
    logic             dec;
    logic [CW-1:0]    k;
    logic [WIN*8-1:0] post_flat;
    logic [CW-1:0]    post_cnt;
    logic             fin;
    logic [63:0]      rep_last_shift;

    // Effective lengths and the window count that triggers a decision.
    always_comb begin
        plen = CW'(eff_len(i_cfg.pattern_length, 4'd1, 4'(PCAP)));
        rlen = eff_len(i_cfg.replacement_length, 4'd0, 4'(RCAP));
        need = plen + CW'(i_cfg.whole_word_mode);
    end

    assign o_in_ready = !r_flush && !i_q_full;
    assign acc        = i_in_valid && o_in_ready;
    assign eot_step   = (acc && i_in_data.end_of_text) || r_flush;

    // Window as seen this cycle, with an accepted byte appended at the fill point.
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            v_flat[i*8 +: 8] = (acc && (r_cnt == CW'(i))) ? i_in_data.text_byte
                                                          : r_win[i*8 +: 8];
        end
        vcnt = r_cnt + CW'(acc);
    end

    // Parallel compare of the oldest bytes against the pattern.
    always_comb begin
        mismatch = 1'b0;
        for (int i = 0; i < PCAP; i++) begin
            if ((CW'(i) < plen) && (v_flat[i*8 +: 8] != i_cfg.pattern_bytes[i*8 +: 8])) begin
                mismatch = 1'b1;
            end
        end
        matched = (r_skip == '0) && (vcnt >= plen) && !mismatch;
    end

    // Word-border test on the last emitted byte and the byte after the match.
    always_comb begin
        nxt_shift = v_flat >> {plen, 3'b000};
        next_byte = (vcnt > plen) ? nxt_shift[7:0] : 8'h00;
        border_ok = !i_cfg.whole_word_mode || (!is_word(r_prev) && !is_word(next_byte));
        take      = matched && border_ok;
    end

    // Decision: drop the matched bytes or the oldest byte.
    always_comb begin
        dec       = ((acc && (i_in_data.end_of_text || (vcnt == need))) || r_flush) &&
                    !i_q_full;
        k         = take ? plen : CW'(1);
        post_flat = v_flat >> {k, 3'b000};
        post_cnt  = vcnt - k;
        fin       = eot_step && (post_cnt == '0);
        rep_last_shift = i_cfg.replacement_bytes >> {rlen - 4'd1, 3'b000};
    end

    // Command toward the back end; empty replacements are only sent to close a text.
    always_comb begin
        o_cmd.kind = take ? CMD_REPLACE : CMD_LITERAL;
        o_cmd.lit  = v_flat[7:0];
        o_cmd.eot  = eot_step;
        o_cmd.fin  = fin;
        o_push     = dec && (!take || (rlen != 4'd0) || fin);
    end

    // Next window, skip count, last emitted byte and flush flag.
    always_comb begin
        n_win   = r_win;
        n_cnt   = r_cnt;
        n_skip  = r_skip;
        n_prev  = r_prev;
        n_flush = r_flush;
        if (acc) begin
            n_win = v_flat;
            n_cnt = vcnt;
        end
        if (dec) begin
            n_win = post_flat;
            n_cnt = post_cnt;
            if (take) begin
                n_skip = '0;
                n_prev = (rlen != 4'd0) ? rep_last_shift[7:0] : r_prev;
            end else if (matched) begin
                n_skip = plen - CW'(1);
                n_prev = v_flat[7:0];
            end else begin
                n_skip = (r_skip != '0) ? (r_skip - CW'(1)) : '0;
                n_prev = v_flat[7:0];
            end
            if (eot_step) begin
                if (post_cnt == '0) begin
                    n_skip  = '0;
                    n_prev  = 8'h00;
                    n_flush = 1'b0;
                end else begin
                    n_flush = 1'b1;
                end
            end
        end
        if (i_clear) begin
            n_cnt   = '0;
            n_skip  = '0;
            n_prev  = 8'h00;
            n_flush = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_skip  <= '0;
            r_prev  <= 8'h00;
            r_flush <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_skip  <= n_skip;
            r_prev  <= n_prev;
            r_flush <= n_flush;
        end
    end

    // Window bytes.
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    `SFRW_ASSERT(a_cnt_below_need, i_clk, i_rst_n, !r_flush, r_cnt < need, "window over need")
    `SFRW_ASSERT(a_flush_has_bytes, i_clk, i_rst_n, r_flush, r_cnt != '0, "flush with empty window")
    `SFRW_ASSERT(a_skip_short, i_clk, i_rst_n, r_skip != '0, r_skip < plen, "skip too long")

endmodule

/* src/sfrw_queue.sv */
// ============================================================================
// Stream find-and-replace command queue
// Small register queue that decouples the front end from the back end.
// ============================================================================
module sfrw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sfrw_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_vld,
    output sfrw_pkg::t_cmd o_head,
    input  logic           i_pop
);
    import sfrw_pkg::*;

    localparam int QAW = $clog2(Q_DEPTH);

    t_cmd           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wptr, n_wptr;
    logic [QAW-1:0] r_rptr, n_rptr;
    logic [QAW:0]   r_cnt, n_cnt;

    assign o_full = (r_cnt == (QAW+1)'(Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_head = r_mem[r_rptr];

    // Pointer and occupancy updates.
    always_comb begin
        n_wptr = i_push ? (r_wptr + QAW'(1)) : r_wptr;
        n_rptr = i_pop ? (r_rptr + QAW'(1)) : r_rptr;
        n_cnt  = r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // Entry write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

/* src/sfrw_back.sv */
// ============================================================================
// Stream find-and-replace back end
// Expands queued commands into output words one byte per cycle while the
// output register can take a word, holds the newest byte of a text's final
// step to mark the last word, and drives the output register.
// ============================================================================
`include "stream_find_replace_word_core_macros.svh"

module sfrw_back #(
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfrw_pkg::t_cfg i_cfg,
    input  logic           i_vld,
    input  sfrw_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sfrw_pkg::t_out o_out_data
);
    import sfrw_pkg::*;

    localparam int RCAP = (MAX_REPLACEMENT < PACK_BYTES) ? MAX_REPLACEMENT : PACK_BYTES;
    localparam int IW   = $clog2(RCAP + 1);

    logic [IW-1:0] r_idx, n_idx;
    logic          r_pend_vld, n_pend_vld;
    logic [7:0]    r_pend, n_pend;
    logic          r_out_vld, n_out_vld;
    t_out          r_out, n_out;

    logic [IW-1:0] n_bytes;
    logic [63:0]   rep_shift;
    logic [7:0]    cur_byte;
    logic          out_free;
    logic          go;
    logic          produce;
    logic          release_pend;

    // Byte count and current byte of the head command.
    always_comb begin
        n_bytes   = (i_head.kind == CMD_REPLACE)
                  ? IW'(eff_len(i_cfg.replacement_length, 4'd0, 4'(RCAP)))
                  : IW'(1);
        rep_shift = i_cfg.replacement_bytes >> {r_idx, 3'b000};
        cur_byte  = (i_head.kind == CMD_REPLACE) ? rep_shift[7:0] : i_head.lit;
    end

    // One step per cycle while the output register can take a word.
    always_comb begin
        out_free     = !r_out_vld || i_out_ready;
        go           = i_vld && out_free;
        produce      = go && (r_idx < n_bytes);
        release_pend = go && !(r_idx < n_bytes);
        o_pop        = (produce && (r_idx == (n_bytes - IW'(1))) && !i_head.fin) ||
                       release_pend;
    end

    // Output register, pending byte and byte index.
    always_comb begin
        n_idx      = r_idx;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        if (produce) begin
            n_idx = r_idx + IW'(1);
            if (!i_head.eot) begin
                n_out_vld = 1'b1;
                n_out     = '{out_byte: cur_byte, out_last: 1'b0};
            end else begin
                if (r_pend_vld) begin
                    n_out_vld = 1'b1;
                    n_out     = '{out_byte: r_pend, out_last: 1'b0};
                end
                n_pend_vld = 1'b1;
                n_pend     = cur_byte;
            end
        end
        if (release_pend) begin
            n_pend_vld = 1'b0;
            if (r_pend_vld) begin
                n_out_vld = 1'b1;
                n_out     = '{out_byte: r_pend, out_last: 1'b1};
            end
        end
        if (o_pop) begin
            n_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_idx      <= n_idx;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `SFRW_ASSERT(a_idx_has_cmd, i_clk, i_rst_n, r_idx != '0, i_vld, "index without command")
    `SFRW_ASSERT(a_pend_in_end, i_clk, i_rst_n, r_pend_vld && i_vld, i_head.eot, "stray pending byte")
    `SFRW_ASSERT_NEXT(a_release_last, i_clk, i_rst_n, release_pend && r_pend_vld, r_out_vld && r_out.out_last, "last word missing")

endmodule

/* src/stream_find_replace_word_core.sv */
// ============================================================================
// Stream find-and-replace core
// Whole-word capable find and replace on a byte stream, with an APB-style
// configuration port for pattern, replacement and mode.
// ============================================================================
//
//   Channel   Direction   Handshake                    Payload
//   in        sink        i_in_valid / o_in_ready      i_in_data (t_in)
//   out       source      o_out_valid / i_out_ready    o_out_data (t_out)
//   cfg       APB slave   psel, penable, pwrite        paddr, pwdata, prdata
//
// One text byte is taken per cycle while the command queue has room.
// The final byte of a text starts a flush of the held window: one decision
// per cycle while the queue has room, and no byte is taken until it ends.
// The back end emits one word per cycle while the output is accepted; a replacement
// yields replacement_length words, and a text's final step marks the last word.
// Reset is synchronous and active low; a write to a known register also drops a text in progress.
//
module stream_find_replace_word_core #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sfrw_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sfrw_pkg::t_out o_out_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [5:0]     paddr,
    input  logic [63:0]    pwdata,
    output logic [63:0]    prdata,
    output logic           pready
);
    import sfrw_pkg::*;

    t_cfg       r_cfg, n_cfg;
    logic       cfg_wr;
    logic       cfg_clear;
    logic [2:0] reg_idx;

    logic       q_push;
    logic       q_full;
    logic       q_vld;
    logic       q_pop;
    t_cmd       q_in;
    t_cmd       q_head;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    // Register write decode; a write to a known register restarts the stream.
    always_comb begin
        n_cfg     = r_cfg;
        cfg_clear = 1'b0;
        if (cfg_wr) begin
            cfg_clear = 1'b1;
            unique case (reg_idx)
                REG_PATTERN_BYTES:      n_cfg.pattern_bytes      = pwdata;
                REG_PATTERN_LENGTH:     n_cfg.pattern_length     = pwdata[3:0];
                REG_REPLACEMENT_BYTES:  n_cfg.replacement_bytes  = pwdata;
                REG_REPLACEMENT_LENGTH: n_cfg.replacement_length = pwdata[3:0];
                REG_WHOLE_WORD_MODE:    n_cfg.whole_word_mode    = pwdata[0];
                default:                cfg_clear                = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{pattern_bytes: 64'h0, pattern_length: 4'd1,
                       replacement_bytes: 64'h0, replacement_length: 4'd0,
                       whole_word_mode: 1'b0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_BYTES:      prdata = r_cfg.pattern_bytes;
            REG_PATTERN_LENGTH:     prdata = {60'h0, r_cfg.pattern_length};
            REG_REPLACEMENT_BYTES:  prdata = r_cfg.replacement_bytes;
            REG_REPLACEMENT_LENGTH: prdata = {60'h0, r_cfg.replacement_length};
            REG_WHOLE_WORD_MODE:    prdata = {63'h0, r_cfg.whole_word_mode};
            default:                prdata = 64'h0;
        endcase
    end

    sfrw_front #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_clear),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in)
    );

    sfrw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    sfrw_back #(
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_vld       (q_vld),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
